@@ src/lsb_stego_extract_defines.svh @@
// ----------------------------------------------------------------------------
// LSB stego extract assertion macros
// Assertion wrappers shared by the extractor RTL. The properties are compiled
// for simulation and drop out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LSB_STEGO_EXTRACT_DEFINES_SVH
`define LSB_STEGO_EXTRACT_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every rising edge of clk, quiet while rst_n is low.
`define LSBSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge of clk, also during reset.
`define LSBSE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LSBSE_ASSERT(lbl, prop, msg)
`define LSBSE_ASSERT_RST(lbl, prop, msg)

`endif

`endif

@@ src/lsbse_pkg.sv @@
// ----------------------------------------------------------------------------
// LSB stego extract package
// Parse phases, result kinds, fixed widths and the result record shared by
// the bit lanes, the merge stage and the top level.
// ----------------------------------------------------------------------------
package lsbse_pkg;

  // Fixed field widths.
  localparam int MARKER_W  = 24;
  localparam int BYTE_W    = 8;
  localparam int VALUE_W   = 32;
  localparam int NUM_LANES = 3;

  // Marker after reset: the UTF-8 bytes of a heart sign.
  localparam logic [MARKER_W-1:0] MARKER_RESET = 24'hE29DA4;

  typedef enum logic [1:0] {
    PH_MARKER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_MESSAGE = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_LENGTH   = 2'd1,
    KIND_MISMATCH = 2'd2
  } kind_t;

  // One result as found by a lane; got marks that the lane produced it.
  typedef struct packed {
    logic               got;
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } result_t;

endpackage

@@ src/lsbse_lane.sv @@
// ----------------------------------------------------------------------------
// LSB stego extract bit lane
// Advances the parse state by one stream bit: shifts it into the current
// field, closes the field when its bit count is reached and builds a result.
// ----------------------------------------------------------------------------
module lsbse_lane
  import lsbse_pkg::*;
#(
  parameter int LENGTH_BITS = 32,
  parameter int CNT_W       = 6,
  parameter int SHIFT_W     = 32
) (
  input  logic                   bit_i,
  input  logic [MARKER_W-1:0]    marker_i,
  input  phase_t                 phase_i,
  input  logic [CNT_W-1:0]       cnt_i,
  input  logic [SHIFT_W-1:0]     shift_i,
  input  logic [LENGTH_BITS-1:0] left_i,
  output phase_t                 phase_o,
  output logic [CNT_W-1:0]       cnt_o,
  output logic [SHIFT_W-1:0]     shift_o,
  output logic [LENGTH_BITS-1:0] left_o,
  output result_t                res_o
);

  logic [CNT_W-1:0]       cnt_inc;
  logic [MARKER_W-1:0]    sh_mark;
  logic [LENGTH_BITS-1:0] sh_len;
  logic [BYTE_W-1:0]      sh_byte;

  // Candidate field contents with the new bit shifted in.
  assign cnt_inc = cnt_i + CNT_W'(1);
  assign sh_mark = {shift_i[MARKER_W-2:0], bit_i};
  assign sh_len  = {shift_i[LENGTH_BITS-2:0], bit_i};
  assign sh_byte = {shift_i[BYTE_W-2:0], bit_i};

  // Per-phase handling of one bit.
  always_comb begin
    phase_o   = phase_i;
    cnt_o     = cnt_i;
    shift_o   = shift_i;
    left_o    = left_i;
    res_o     = '0;
    res_o.kind = KIND_BYTE;
    unique case (phase_i)
      PH_MARKER: begin
        cnt_o   = cnt_inc;
        shift_o = SHIFT_W'(sh_mark);
        if (cnt_inc == CNT_W'(MARKER_W)) begin
          cnt_o   = '0;
          shift_o = '0;
          if (sh_mark == marker_i) begin
            phase_o = PH_LENGTH;
          end else begin
            res_o.got   = 1'b1;
            res_o.kind  = KIND_MISMATCH;
            res_o.value = '0;
            res_o.last  = 1'b1;
            phase_o     = PH_DONE;
          end
        end
      end
      PH_LENGTH: begin
        cnt_o   = cnt_inc;
        shift_o = SHIFT_W'(sh_len);
        if (cnt_inc == CNT_W'(LENGTH_BITS)) begin
          cnt_o       = '0;
          shift_o     = '0;
          left_o      = sh_len;
          res_o.got   = 1'b1;
          res_o.kind  = KIND_LENGTH;
          res_o.value = VALUE_W'(sh_len);
          res_o.last  = (sh_len == '0);
          phase_o     = (sh_len == '0) ? PH_DONE : PH_MESSAGE;
        end
      end
      PH_MESSAGE: begin
        cnt_o   = cnt_inc;
        shift_o = SHIFT_W'(sh_byte);
        if (cnt_inc == CNT_W'(BYTE_W)) begin
          cnt_o       = '0;
          shift_o     = '0;
          left_o      = left_i - LENGTH_BITS'(1);
          res_o.got   = 1'b1;
          res_o.kind  = KIND_BYTE;
          res_o.value = VALUE_W'(sh_byte);
          res_o.last  = (left_i == LENGTH_BITS'(1));
          if (left_i == LENGTH_BITS'(1)) begin
            phase_o = PH_DONE;
          end
        end
      end
      PH_DONE: begin
        phase_o = PH_DONE;
      end
      default: begin
        phase_o = PH_DONE;
      end
    endcase
  end

endmodule

@@ src/lsbse_merge.sv @@
// ----------------------------------------------------------------------------
// LSB stego extract merge stage
// Combines the lane results of one pixel: the earliest lane that produced a
// result wins, later ones are dropped.
// ----------------------------------------------------------------------------
module lsbse_merge
  import lsbse_pkg::*;
(
  input  result_t lane_res_i [NUM_LANES],
  output result_t res_o
);

  // Earliest lane takes priority.
  always_comb begin
    res_o      = '0;
    res_o.kind = KIND_BYTE;
    for (int i = NUM_LANES - 1; i >= 0; i--) begin
      if (lane_res_i[i].got) begin
        res_o = lane_res_i[i];
      end
    end
  end

endmodule

@@ src/lsb_stego_extract.sv @@
// A result is registered and appears on out_valid in the cycle after its pixel is accepted.
// One pixel per cycle unless a pending result waits on out_ready; three bit lanes chained
// combinationally update the parse state, and a single output register decouples the two channels.
// Reset (synchronous, rst_n low): parsing restarts at the marker, the marker
// register returns to 0xE29DA4 and no result is pending.
// ----------------------------------------------------------------------------
// LSB stego extract top level
// Reads one stream bit from each color LSB of a pixel, checks the marker,
// reports the message length and emits the message bytes.
// ----------------------------------------------------------------------------
`include "lsb_stego_extract_defines.svh"

module lsb_stego_extract
  import lsbse_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [MARKER_W-1:0] cfg_marker_word,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_frame_start,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [VALUE_W-1:0]  out_value,
  output logic                out_last
);

  localparam int FIELD_MAX = (LENGTH_BITS > MARKER_W) ? LENGTH_BITS : MARKER_W;
  localparam int CNT_W     = $clog2(FIELD_MAX + 1);
  localparam int SHIFT_W   = FIELD_MAX;

  logic [MARKER_W-1:0]    marker_r;
  phase_t                 phase_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [SHIFT_W-1:0]     shift_r;
  logic [LENGTH_BITS-1:0] left_r;
  phase_t                 phase_nxt;
  logic [CNT_W-1:0]       cnt_nxt;
  logic [SHIFT_W-1:0]     shift_nxt;
  logic [LENGTH_BITS-1:0] left_nxt;

  logic                   out_valid_r;
  kind_t                  kind_r;
  logic [VALUE_W-1:0]     value_r;
  logic                   last_r;

  phase_t                 ph_c    [NUM_LANES+1];
  logic [CNT_W-1:0]       cnt_c   [NUM_LANES+1];
  logic [SHIFT_W-1:0]     shift_c [NUM_LANES+1];
  logic [LENGTH_BITS-1:0] left_c  [NUM_LANES+1];
  logic [NUM_LANES-1:0]   lane_bit;
  result_t                lane_res [NUM_LANES];
  result_t                merged;
  logic                   in_fire;

  assign in_fire   = in_valid & in_ready;
  assign in_ready  = ~out_valid_r | out_ready;
  assign cfg_ready = 1'b1;

  // Red carries the first bit of the pixel, blue the last.
  assign lane_bit[0] = in_red[0];
  assign lane_bit[1] = in_green[0];
  assign lane_bit[2] = in_blue[0];

  // A frame start clears the parse state before the first lane.
  always_comb begin
    if (in_frame_start) begin
      ph_c[0]    = PH_MARKER;
      cnt_c[0]   = '0;
      shift_c[0] = '0;
      left_c[0]  = '0;
    end else begin
      ph_c[0]    = phase_r;
      cnt_c[0]   = cnt_r;
      shift_c[0] = shift_r;
      left_c[0]  = left_r;
    end
  end

  // Bit lanes, each handing its state to the next.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    lsbse_lane #(
      .LENGTH_BITS (LENGTH_BITS),
      .CNT_W       (CNT_W),
      .SHIFT_W     (SHIFT_W)
    ) u_lane (
      .bit_i    (lane_bit[g]),
      .marker_i (marker_r),
      .phase_i  (ph_c[g]),
      .cnt_i    (cnt_c[g]),
      .shift_i  (shift_c[g]),
      .left_i   (left_c[g]),
      .phase_o  (ph_c[g+1]),
      .cnt_o    (cnt_c[g+1]),
      .shift_o  (shift_c[g+1]),
      .left_o   (left_c[g+1]),
      .res_o    (lane_res[g])
    );
  end

  lsbse_merge u_merge (
    .lane_res_i (lane_res),
    .res_o      (merged)
  );

  assign phase_nxt = ph_c[NUM_LANES];
  assign cnt_nxt   = cnt_c[NUM_LANES];
  assign shift_nxt = shift_c[NUM_LANES];
  assign left_nxt  = left_c[NUM_LANES];

  // Marker register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= MARKER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      marker_r <= cfg_marker_word;
    end
  end

  // Parse state advances once per accepted pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MARKER;
      cnt_r   <= '0;
      shift_r <= '0;
      left_r  <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
      left_r  <= left_nxt;
    end
  end

  // Output request valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= merged.got;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output request payload.
  always_ff @(posedge clk) begin
    if (in_fire && merged.got) begin
      kind_r  <= merged.kind;
      value_r <= merged.value;
      last_r  <= merged.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_value = value_r;
  assign out_last  = last_r;

  // Checks on the parse state and the results it produces.
  `LSBSE_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid_r, "result pending after reset")
  `LSBSE_ASSERT(a_mismatch_form, out_valid_r && kind_r == KIND_MISMATCH |-> value_r == '0 && last_r, "bad mismatch result")
  `LSBSE_ASSERT(a_byte_range, out_valid_r && kind_r == KIND_BYTE |-> value_r[VALUE_W-1:BYTE_W] == '0, "message byte out of range")
  `LSBSE_ASSERT(a_done_sticks, phase_r == PH_DONE && in_fire && !in_frame_start |=> phase_r == PH_DONE, "left done without frame start")
  `LSBSE_ASSERT(a_message_has_bytes, phase_r == PH_MESSAGE |-> left_r != '0, "message phase with no bytes left")

endmodule
